@@ hw/rtl/bmcp_pkg.sv @@
// Shared constants, register indexes and control/status types for the block-mean pixelator.
`timescale 1ns / 1ps

package bmcp_pkg;

    // Default bounds handed to the top-level parameters
    localparam int MAX_BLOCK_SIDE    = 64;
    localparam int MAX_BLOCKS_ACROSS = 64;

    // Block rows down the frame saturate here
    localparam int MAX_BLOCKS_DOWN = 64;

    // Fixed field widths
    localparam int PIX_W      = 8;
    localparam int TILE_W     = 6;
    localparam int QUO_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int CMP_W      = CFG_DATA_W + 1;

    // Register value after reset
    localparam logic [CFG_DATA_W-1:0] CFG_RESET = 7'd8;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_WIDTH   = 3'd0,
        REG_BLOCK_HEIGHT  = 3'd1,
        REG_BLOCKS_ACROSS = 3'd2,
        REG_BLOCKS_DOWN   = 3'd3
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [TILE_W-1:0] tile_row;
        logic [TILE_W-1:0] tile_col;
        logic [PIX_W-1:0]  mean_red;
        logic [PIX_W-1:0]  mean_green;
        logic [PIX_W-1:0]  mean_blue;
        logic              frame_done;
    } tile_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic update;
        logic div_step;
        logic publish;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last;
        logic div_last;
        logic out_free;
    } dp_sts_t;

endpackage

@@ hw/rtl/bmcp_intf.sv @@
// Stream interfaces for pixels, finished tiles and configuration writes.
`timescale 1ns / 1ps

interface bmcp_pix_if;
    logic                        valid;
    logic                        ready;
    logic [bmcp_pkg::PIX_W-1:0]  red_in;
    logic [bmcp_pkg::PIX_W-1:0]  green_in;
    logic [bmcp_pkg::PIX_W-1:0]  blue_in;

    modport source (output valid, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface bmcp_tile_if;
    logic                        valid;
    logic                        ready;
    logic [bmcp_pkg::TILE_W-1:0] tile_row;
    logic [bmcp_pkg::TILE_W-1:0] tile_col;
    logic [bmcp_pkg::PIX_W-1:0]  mean_red;
    logic [bmcp_pkg::PIX_W-1:0]  mean_green;
    logic [bmcp_pkg::PIX_W-1:0]  mean_blue;
    logic                        frame_done;

    modport source (output valid, tile_row, tile_col, mean_red, mean_green, mean_blue,
                    frame_done, input ready);
    modport sink   (input valid, tile_row, tile_col, mean_red, mean_green, mean_blue,
                    frame_done, output ready);
endinterface

interface bmcp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bmcp_pkg::CFG_IDX_W-1:0]  index;
    logic [bmcp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/block_mean_color_pixelate.sv @@
// Top level of the block-mean mosaic pixelator.
//
//   Channel  Dir  Payload                                                  Transfer
//   pix      in   red_in, green_in, blue_in                                valid & ready
//   tile     out  tile_row, tile_col, mean_red/green/blue, frame_done      valid & ready
//   cfg      in   index (0 width, 1 height, 2 across, 3 down), data        valid & ready
//
// A pixel is transferred with a column sum read, then accumulated and written back.
// A pixel that closes a block is transferred and accumulated, then takes 8 divider steps
// (one quotient bit per step, three channels in parallel), then loads the output register once it is free.
// Reset and every write to a listed register invalidate the column sums and clear the position.
// A held tile stalls the block only when the next tile is ready to publish.
`timescale 1ns / 1ps

module block_mean_color_pixelate #(
    parameter int MAX_BLOCK_SIDE    = bmcp_pkg::MAX_BLOCK_SIDE,
    parameter int MAX_BLOCKS_ACROSS = bmcp_pkg::MAX_BLOCKS_ACROSS
) (
    input  logic        clk,
    input  logic        rst_n,
    bmcp_pix_if.sink    pix,
    bmcp_tile_if.source tile,
    bmcp_cfg_if.sink    cfg
);

    bmcp_pkg::ctrl_cmd_t cmd;
    bmcp_pkg::dp_sts_t   sts;
    bmcp_pkg::cfg_wr_t   cfg_wr;
    bmcp_pkg::pixel_t    pix_data;
    bmcp_pkg::tile_t     tile_data;
    logic                in_ready;
    logic                out_valid;

    // Configuration writes are always taken
    assign cfg.ready    = 1'b1;
    assign cfg_wr.we    = cfg.valid;
    assign cfg_wr.index = cfg.index;
    assign cfg_wr.data  = cfg.data;

    assign pix.ready      = in_ready;
    assign pix_data.red   = pix.red_in;
    assign pix_data.green = pix.green_in;
    assign pix_data.blue  = pix.blue_in;

    assign tile.valid      = out_valid;
    assign tile.tile_row   = tile_data.tile_row;
    assign tile.tile_col   = tile_data.tile_col;
    assign tile.mean_red   = tile_data.mean_red;
    assign tile.mean_green = tile_data.mean_green;
    assign tile.mean_blue  = tile_data.mean_blue;
    assign tile.frame_done = tile_data.frame_done;

    bmcp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bmcp_dp #(
        .MAX_BLOCK_SIDE    (MAX_BLOCK_SIDE),
        .MAX_BLOCKS_ACROSS (MAX_BLOCKS_ACROSS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .pix       (pix_data),
        .out_ready (tile.ready),
        .out_valid (out_valid),
        .out_tile  (tile_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

@@ hw/rtl/bmcp_ctrl.sv @@
// Controller state machine: sequences accept, accumulate, divide and publish.
`timescale 1ns / 1ps

module bmcp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bmcp_pkg::dp_sts_t   sts,
    output bmcp_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_UPDATE  = 4'b0010,
        ST_DIVIDE  = 4'b0100,
        ST_PUBLISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode state into datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = sts.last ? ST_DIVIDE : ST_IDLE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_PUBLISH;
                end
            end
            ST_PUBLISH:
            begin
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A transfer is always followed by its accumulate cycle
    a_take_then_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> cmd.update)
        else $error("accepted pixel not followed by update");

    // A pixel that closes no block frees the input right away
    a_plain_pixel_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && !sts.last) |=> in_ready)
        else $error("input not ready after plain pixel");

    // Hold off the input while a closed block is divided
    a_close_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && sts.last) |=> !in_ready)
        else $error("input ready during divide");

endmodule

@@ hw/rtl/bmcp_dp.sv @@
// Datapath: config registers, position counters, column sum memory, divider, output register.
`timescale 1ns / 1ps

module bmcp_dp #(
    parameter int MAX_BLOCK_SIDE    = bmcp_pkg::MAX_BLOCK_SIDE,
    parameter int MAX_BLOCKS_ACROSS = bmcp_pkg::MAX_BLOCKS_ACROSS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bmcp_pkg::cfg_wr_t   cfg_wr,
    input  bmcp_pkg::pixel_t    pix,
    input  logic                out_ready,
    output logic                out_valid,
    output bmcp_pkg::tile_t     out_tile,
    input  bmcp_pkg::ctrl_cmd_t cmd,
    output bmcp_pkg::dp_sts_t   sts
);

    localparam int CFG_MAX  = 2 ** bmcp_pkg::CFG_DATA_W - 1;
    localparam int SIDE_EFF = (MAX_BLOCK_SIDE < CFG_MAX) ? MAX_BLOCK_SIDE : CFG_MAX;
    localparam int COLS_EFF = (MAX_BLOCKS_ACROSS < CFG_MAX) ? MAX_BLOCKS_ACROSS : CFG_MAX;
    localparam int SIDE_W   = $clog2(SIDE_EFF + 1);
    localparam int COL_W    = (COLS_EFF > 1) ? $clog2(COLS_EFF) : 1;
    localparam int CNT_W    = $clog2(COLS_EFF + 1);
    localparam int N_W      = $clog2(SIDE_EFF * SIDE_EFF + 1);
    localparam int SUM_W    = $clog2((2 ** bmcp_pkg::PIX_W - 1) * SIDE_EFF * SIDE_EFF + 1);
    localparam int STEP_W   = $clog2(bmcp_pkg::QUO_W);
    localparam int CMP_W    = bmcp_pkg::CMP_W;
    localparam int CFG_W    = bmcp_pkg::CFG_DATA_W;

    // Zero acts as one, large values saturate
    function automatic logic [CFG_W-1:0] clamp_reg(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        begin
            r = v;
            if (v == '0)
            begin
                r = CFG_W'(1);
            end
            else if (v > hi)
            begin
                r = hi;
            end
            return r;
        end
    endfunction

    logic [CFG_W-1:0] bw_cfg_reg;
    logic [CFG_W-1:0] bh_cfg_reg;
    logic [CFG_W-1:0] ba_cfg_reg;
    logic [CFG_W-1:0] bd_cfg_reg;

    logic [SIDE_W-1:0] bw;
    logic [SIDE_W-1:0] bh;
    logic [CNT_W-1:0]  ba;
    logic [CFG_W-1:0]  bd;
    logic [N_W-1:0]    npix;

    logic restart;

    logic [SIDE_W-1:0]             x_reg, x_next;
    logic [SIDE_W-1:0]             y_reg, y_next;
    logic [COL_W-1:0]              col_reg, col_next;
    logic [bmcp_pkg::TILE_W-1:0]   row_reg, row_next;

    logic [CMP_W-1:0] x_inc, y_inc, col_inc, row_inc;
    logic             x_wrap, y_wrap, col_wrap, row_wrap;
    logic             block_last;
    logic             frame_last;

    logic [COLS_EFF-1:0] valid_reg;

    logic [2:0][SUM_W-1:0] mem [COLS_EFF];
    logic [2:0][SUM_W-1:0] rd_data_reg;
    logic                  rd_valid_reg;
    logic [2:0][SUM_W-1:0] sum_new;
    logic [2:0][bmcp_pkg::PIX_W-1:0] pix_reg;

    logic [SUM_W-1:0]                rem_reg [3];
    logic [bmcp_pkg::QUO_W-1:0]      quo_reg [3];
    logic [SUM_W-1:0]                div_reg;
    logic [STEP_W-1:0]               div_cnt_reg;
    logic [2:0]                      ge;

    logic [bmcp_pkg::TILE_W-1:0] res_row_reg;
    logic [bmcp_pkg::TILE_W-1:0] res_col_reg;
    logic                        res_done_reg;

    logic            out_valid_reg;
    bmcp_pkg::tile_t out_tile_reg;

    // Clamp configuration into working values
    always_comb
    begin
        bw   = SIDE_W'(clamp_reg(bw_cfg_reg, CFG_W'(SIDE_EFF)));
        bh   = SIDE_W'(clamp_reg(bh_cfg_reg, CFG_W'(SIDE_EFF)));
        ba   = CNT_W'(clamp_reg(ba_cfg_reg, CFG_W'(COLS_EFF)));
        bd   = clamp_reg(bd_cfg_reg, CFG_W'(bmcp_pkg::MAX_BLOCKS_DOWN));
        npix = N_W'(bw * bh);
    end

    // Any write to a listed register restarts the frame
    assign restart = cfg_wr.we &&
                     (cfg_wr.index == bmcp_pkg::REG_BLOCK_WIDTH   ||
                      cfg_wr.index == bmcp_pkg::REG_BLOCK_HEIGHT  ||
                      cfg_wr.index == bmcp_pkg::REG_BLOCKS_ACROSS ||
                      cfg_wr.index == bmcp_pkg::REG_BLOCKS_DOWN);

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_cfg_reg <= bmcp_pkg::CFG_RESET;
            bh_cfg_reg <= bmcp_pkg::CFG_RESET;
            ba_cfg_reg <= bmcp_pkg::CFG_RESET;
            bd_cfg_reg <= bmcp_pkg::CFG_RESET;
        end
        else if (cfg_wr.we)
        begin
            case (cfg_wr.index)
                bmcp_pkg::REG_BLOCK_WIDTH:   bw_cfg_reg <= cfg_wr.data;
                bmcp_pkg::REG_BLOCK_HEIGHT:  bh_cfg_reg <= cfg_wr.data;
                bmcp_pkg::REG_BLOCKS_ACROSS: ba_cfg_reg <= cfg_wr.data;
                bmcp_pkg::REG_BLOCKS_DOWN:   bd_cfg_reg <= cfg_wr.data;
                default:
                begin
                end
            endcase
        end
    end

    // Advance raster position
    always_comb
    begin
        x_inc   = CMP_W'(x_reg) + CMP_W'(1);
        y_inc   = CMP_W'(y_reg) + CMP_W'(1);
        col_inc = CMP_W'(col_reg) + CMP_W'(1);
        row_inc = CMP_W'(row_reg) + CMP_W'(1);

        x_wrap   = x_inc >= CMP_W'(bw);
        y_wrap   = y_inc >= CMP_W'(bh);
        col_wrap = col_inc >= CMP_W'(ba);
        row_wrap = row_inc >= CMP_W'(bd);

        block_last = x_wrap && y_wrap;
        frame_last = row_wrap && col_wrap;

        x_next   = x_reg;
        y_next   = y_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.update)
        begin
            x_next = SIDE_W'(x_inc);
            if (x_wrap)
            begin
                x_next   = '0;
                col_next = COL_W'(col_inc);
                if (col_wrap)
                begin
                    col_next = '0;
                    y_next   = SIDE_W'(y_inc);
                    if (y_wrap)
                    begin
                        y_next   = '0;
                        row_next = bmcp_pkg::TILE_W'(row_inc);
                        if (row_wrap)
                        begin
                            row_next = '0;
                        end
                    end
                end
            end
        end
    end

    // Hold position and column valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg     <= '0;
            y_reg     <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            valid_reg <= '0;
        end
        else if (restart)
        begin
            x_reg     <= '0;
            y_reg     <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            valid_reg <= '0;
        end
        else
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            col_reg <= col_next;
            row_reg <= row_next;
            if (cmd.update)
            begin
                valid_reg[col_reg] <= !block_last;
            end
        end
    end

    // Add the pixel to the column sums
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum_new[i] = (rd_valid_reg ? rd_data_reg[i] : SUM_W'(0)) + SUM_W'(pix_reg[i]);
        end
    end

    // Column sum memory: read on transfer, write back on update unless the block closes
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            rd_data_reg <= mem[col_reg];
        end
        if (cmd.update && !block_last)
        begin
            mem[col_reg] <= sum_new;
        end
    end

    // Capture pixel and column valid bit
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            pix_reg[2]   <= pix.red;
            pix_reg[1]   <= pix.green;
            pix_reg[0]   <= pix.blue;
            rd_valid_reg <= valid_reg[col_reg];
        end
    end

    // Compare each remainder against the shifted divisor
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ge[i] = rem_reg[i] >= div_reg;
        end
    end

    // Restoring divider, one quotient bit per step
    always_ff @(posedge clk)
    begin
        if (cmd.update && block_last)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[i] <= sum_new[i];
                quo_reg[i] <= '0;
            end
            div_reg      <= SUM_W'(npix) << (bmcp_pkg::QUO_W - 1);
            res_row_reg  <= row_reg;
            res_col_reg  <= bmcp_pkg::TILE_W'(col_reg);
            res_done_reg <= frame_last;
        end
        else if (cmd.div_step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (ge[i])
                begin
                    rem_reg[i] <= rem_reg[i] - div_reg;
                end
                quo_reg[i] <= {quo_reg[i][bmcp_pkg::QUO_W-2:0], ge[i]};
            end
            div_reg <= div_reg >> 1;
        end
    end

    // Count divider steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.update)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + STEP_W'(1);
        end
    end

    // Output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_tile_reg.tile_row   <= res_row_reg;
            out_tile_reg.tile_col   <= res_col_reg;
            out_tile_reg.mean_red   <= quo_reg[2];
            out_tile_reg.mean_green <= quo_reg[1];
            out_tile_reg.mean_blue  <= quo_reg[0];
            out_tile_reg.frame_done <= res_done_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_tile     = out_tile_reg;
    assign sts.last     = block_last;
    assign sts.div_last = (div_cnt_reg == STEP_W'(bmcp_pkg::QUO_W - 1));
    assign sts.out_free = !out_valid_reg || out_ready;

    // Closing a block leaves its column reading as zero
    a_close_clears_column: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && block_last) |=> !valid_reg[$past(col_reg)])
        else $error("closed column still marked valid");

    // Divider starts from its first step after a block closes
    a_divider_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && block_last) |=> (div_cnt_reg == '0))
        else $error("divider step count not cleared");

    // Publishing fills the output register
    a_publish_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> out_valid_reg)
        else $error("published tile not presented");

endmodule
